// ===== design/bounded_indexed_list_engine_defines.svh =====
// Assertion helpers for the list engine.
`ifndef BOUNDED_INDEXED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_INDEXED_LIST_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define BLIE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list engine check failed");
// Next-cycle implication.
`define BLIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list engine check failed");
`else
`define BLIE_ASSERT_NOW(label, clk, rst, ante, cons)
`define BLIE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/blie_pkg.sv =====
package blie_pkg;

  localparam int ACT_W = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int CNT_W = 9;

  localparam int DEF_LIST_DEPTH = 256;
  localparam int DEF_DATA_WIDTH = 32;

  localparam logic [CNT_W-1:0] MAX_SIZE_RST = 9'd256;
  localparam int CNT_MAX = 511;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEL_RD,
    S_DEL_WR,
    S_RESP
  } blie_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic del_rd;
    logic del_wr;
    logic load_out;
  } blie_cmd_t;

  typedef struct packed {
    logic del_shift;
    logic del_more;
    logic out_free;
  } blie_stat_t;

endpackage

// ===== design/blie_ram.sv =====
module blie_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/blie_ctrl.sv =====
module blie_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  blie_pkg::blie_stat_t stat,
  output blie_pkg::blie_cmd_t  cmd
);

  blie_pkg::blie_state_t state;
  blie_pkg::blie_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blie_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      blie_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = blie_pkg::S_EXEC;
        end
      end
      blie_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.del_shift ? blie_pkg::S_DEL_RD : blie_pkg::S_RESP;
      end
      blie_pkg::S_DEL_RD: begin
        cmd.del_rd = 1'b1;
        state_next = blie_pkg::S_DEL_WR;
      end
      blie_pkg::S_DEL_WR: begin
        cmd.del_wr = 1'b1;
        state_next = stat.del_more ? blie_pkg::S_DEL_RD : blie_pkg::S_RESP;
      end
      blie_pkg::S_RESP: begin
        // hold until the output register frees up
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          cmd.capture  = in_valid;
          state_next   = in_valid ? blie_pkg::S_EXEC : blie_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = blie_pkg::S_IDLE;
      end
    endcase
    // refuse items while reset is held
    if (rst) begin
      in_ready = 1'b0;
    end
  end

endmodule

// ===== design/blie_dpath.sv =====
module blie_dpath #(
  parameter int LIST_DEPTH = blie_pkg::DEF_LIST_DEPTH,
  parameter int DATA_WIDTH = blie_pkg::DEF_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  blie_pkg::blie_cmd_t               cmd,
  output blie_pkg::blie_stat_t              stat,
  input  logic [blie_pkg::ACT_W-1:0]        action,
  input  logic [blie_pkg::POS_W-1:0]        position,
  input  logic signed [blie_pkg::VAL_W-1:0] value,
  input  logic                              cfg_valid,
  input  logic [blie_pkg::CNT_W-1:0]        max_size,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              ok,
  output logic signed [blie_pkg::VAL_W-1:0] read_value,
  output logic [blie_pkg::CNT_W-1:0]        count,
  output logic                              is_empty,
  output logic                              is_full
);

  localparam int ADDR_W    = $clog2(LIST_DEPTH);
  localparam int DEPTH_LIM = (LIST_DEPTH > blie_pkg::CNT_MAX) ? blie_pkg::CNT_MAX : LIST_DEPTH;
  localparam int CNT_W     = blie_pkg::CNT_W;

  logic [blie_pkg::ACT_W-1:0] item_action;
  logic [blie_pkg::POS_W-1:0] item_position;
  logic [blie_pkg::VAL_W-1:0] item_value;
  logic [CNT_W-1:0]           entry_count;
  logic [CNT_W-1:0]           shift_ptr;
  logic [CNT_W-1:0]           size_limit;
  logic                       res_ok;
  logic                       res_hit;

  logic [CNT_W-1:0]  cap;
  logic              in_range;
  logic              append_ok;
  logic [CNT_W:0]    pos_plus1;
  logic [CNT_W:0]    ptr_plus1;
  logic [CNT_W:0]    ptr_plus2;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign cap = (size_limit < CNT_W'(DEPTH_LIM)) ? size_limit : CNT_W'(DEPTH_LIM);
  assign in_range  = CNT_W'(item_position) < entry_count;
  assign append_ok = entry_count < cap;
  assign pos_plus1 = (CNT_W+1)'(item_position) + 1'b1;
  assign ptr_plus1 = (CNT_W+1)'(shift_ptr) + 1'b1;
  assign ptr_plus2 = (CNT_W+1)'(shift_ptr) + 2'd2;

  assign stat.del_shift = (item_action == blie_pkg::ACT_DELETE) && in_range &&
                          (pos_plus1 < (CNT_W+1)'(entry_count));
  assign stat.del_more  = ptr_plus2 < (CNT_W+1)'(entry_count);
  assign stat.out_free  = !out_valid || out_ready;

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(item_position);
    mem_wdata = DATA_WIDTH'(item_value);
    mem_re    = 1'b0;
    mem_raddr = ADDR_W'(item_position);
    if (cmd.del_wr) begin
      mem_we    = 1'b1;
      mem_waddr = ADDR_W'(shift_ptr);
      mem_wdata = mem_rdata;
    end else if (cmd.exec) begin
      case (item_action)
        blie_pkg::ACT_APPEND: begin
          mem_we    = append_ok;
          mem_waddr = ADDR_W'(entry_count);
        end
        blie_pkg::ACT_UPDATE: begin
          mem_we = in_range;
        end
        blie_pkg::ACT_READ: begin
          mem_re = in_range;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
    if (cmd.del_rd) begin
      mem_re    = 1'b1;
      mem_raddr = ADDR_W'(ptr_plus1);
    end
  end

  blie_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_action   <= action;
      item_position <= position;
      item_value    <= value;
    end
    if (cmd.exec) begin
      shift_ptr <= CNT_W'(item_position);
    end else if (cmd.del_wr) begin
      shift_ptr <= CNT_W'(ptr_plus1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      size_limit  <= blie_pkg::MAX_SIZE_RST;
      res_ok      <= 1'b0;
      res_hit     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        size_limit <= max_size;
      end
      if (cmd.exec) begin
        res_hit <= 1'b0;
        res_ok  <= 1'b0;
        case (item_action)
          blie_pkg::ACT_APPEND: begin
            if (append_ok) begin
              entry_count <= entry_count + 1'b1;
              res_ok      <= 1'b1;
            end
          end
          blie_pkg::ACT_READ: begin
            res_ok  <= in_range;
            res_hit <= in_range;
          end
          blie_pkg::ACT_UPDATE: begin
            res_ok <= in_range;
          end
          blie_pkg::ACT_DELETE: begin
            res_ok <= in_range;
            // drop the tail entry at once when nothing follows it
            if (in_range && !stat.del_shift) begin
              entry_count <= entry_count - 1'b1;
            end
          end
          blie_pkg::ACT_CLEAR: begin
            entry_count <= '0;
            res_ok      <= 1'b1;
          end
          default: begin
            res_ok <= 1'b0;
          end
        endcase
      end else if (cmd.del_wr && !stat.del_more) begin
        entry_count <= entry_count - 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ok         <= res_ok;
      read_value <= res_hit ? blie_pkg::VAL_W'(mem_rdata) : '0;
      count      <= entry_count;
      is_empty   <= entry_count == '0;
      is_full    <= entry_count >= cap;
    end
  end

endmodule

// ===== design/bounded_indexed_list_engine.sv =====
// Steps: exec, then result load (held while the output register is full); a delete
//   that moves entries adds one memory read and one memory write per moved entry.
// A new item is not taken until the previous result loads into the output register.
// Reset (rst, synchronous): count cleared, capacity back to 256, no result pending;
//   list memory contents are not cleared.
`include "bounded_indexed_list_engine_defines.svh"

module bounded_indexed_list_engine #(
  parameter int LIST_DEPTH = blie_pkg::DEF_LIST_DEPTH,
  parameter int DATA_WIDTH = blie_pkg::DEF_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel: capacity limit
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [blie_pkg::CNT_W-1:0]        max_size,
  // request items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [blie_pkg::ACT_W-1:0]        action,
  input  logic [blie_pkg::POS_W-1:0]        position,
  input  logic signed [blie_pkg::VAL_W-1:0] value,
  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              ok,
  output logic signed [blie_pkg::VAL_W-1:0] read_value,
  output logic [blie_pkg::CNT_W-1:0]        count,
  output logic                              is_empty,
  output logic                              is_full
);

  blie_pkg::blie_cmd_t  cmd;
  blie_pkg::blie_stat_t stat;

  // The user must write configuration only while the block is idle; the block does
  // not enforce this and takes it every cycle outside reset.
  assign cfg_ready = !rst;

  // Controller: sequences exec, the delete shift walk and the result handoff.
  // It takes a new item in the same cycle that the previous result moves into
  // the output register, so a finished result never blocks the input side
  // longer than the output register itself is full.
  blie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: item registers, count and capacity, list memory, output register.
  // Delete walks from the hole toward the tail, copying entry i+1 into entry i
  // one entry per read/write pair, then drops the count by one.
  blie_dpath #(
    .LIST_DEPTH (LIST_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (action),
    .position   (position),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .max_size   (max_size),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .ok         (ok),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  // A pending result is never overwritten.
  `BLIE_ASSERT_NOW(a_no_result_overwrite, clk, rst, cmd.load_out, !out_valid || out_ready)
  // An accepted item always goes through exec, with no result load, in the cycle after it is accepted.
  `BLIE_ASSERT_NEXT(a_exec_after_accept, clk, rst, in_valid && in_ready, cmd.exec && !cmd.load_out)
  // The reported count never exceeds the memory depth.
  `BLIE_ASSERT_NOW(a_count_bound, clk, rst, out_valid, 32'(count) <= LIST_DEPTH)

endmodule
